// File: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// File: rtl/isqrt_pkg.sv
// Package: widths, state encoding and control structs of the square root block.
`timescale 1ns / 1ps

package isqrt_pkg;

    localparam int RAD_W  = 64;
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 3;
    localparam int CNT_W  = $clog2(ROOT_W);
    localparam int RAD_TOP = RAD_W - 1;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } isqrt_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic capture;
    } isqrt_cmd_t;

    typedef struct packed {
        logic last;
    } isqrt_status_t;

endpackage

// File: rtl/isqrt_if.sv
// Valid/ready channel interfaces for radicand input and root output.
`timescale 1ns / 1ps

interface isqrt_in_if;
    logic                         valid;
    logic                         ready;
    logic [isqrt_pkg::RAD_W-1:0]  radicand;

    modport source (output valid, output radicand, input ready);
    modport sink (input valid, input radicand, output ready);
endinterface

interface isqrt_out_if;
    logic                         valid;
    logic                         ready;
    logic [isqrt_pkg::ROOT_W-1:0] root;

    modport source (output valid, output root, input ready);
    modport sink (input valid, input root, output ready);
endinterface

// File: rtl/isqrt_dp.sv
// Datapath: radicand shifter, partial remainder, root and bit counter.
`timescale 1ns / 1ps

module isqrt_dp
    import isqrt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [RAD_W-1:0]    radicand,
    input  isqrt_cmd_t          cmd,
    output isqrt_status_t       status,
    output logic [ROOT_W-1:0]   root
);

    logic [RAD_W-1:0]  x_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [ROOT_W-1:0] out_root_reg;
    logic [CNT_W-1:0]  cnt_reg;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic [REM_W:0]    diff;
    logic              keep;
    logic [REM_W-1:0]  rem_next;
    logic [ROOT_W-1:0] root_next;

    always_comb
    begin
        rem_sh    = {rem_reg[REM_W-3:0], x_reg[RAD_TOP -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        diff      = {1'b0, rem_sh} - {1'b0, trial};
        keep      = !diff[REM_W];
        rem_next  = keep ? diff[REM_W-1:0] : rem_sh;
        root_next = {root_reg[ROOT_W-2:0], keep};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.load)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.step)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg    <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cmd.step)
        begin
            x_reg    <= {x_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
        if (cmd.capture)
        begin
            out_root_reg <= root_next;
        end
    end

    assign status.last = (cnt_reg == CNT_W'(ROOT_W - 1));
    assign root        = out_root_reg;

endmodule

// File: rtl/isqrt_ctrl.sv
// Controller: sequences load, iteration and result capture, owns output valid.
`timescale 1ns / 1ps

module isqrt_ctrl
    import isqrt_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  isqrt_status_t status,
    output isqrt_cmd_t    cmd
);

    isqrt_state_t state_reg;
    isqrt_state_t state_next;
    logic         out_valid_reg;
    logic         out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        in_ready       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (!status.last)
                begin
                    cmd.step = 1'b1;
                end
                else if (!out_valid_reg || out_ready)
                begin
                    cmd.step       = 1'b1;
                    cmd.capture    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

// File: rtl/integer_square_root_64.sv
// Top level: 64-bit integer square root, controller plus iterative datapath.
// Returns floor(sqrt(radicand)) as a 32-bit root. One root bit is decided per
// cycle, unless the last iteration holds, by a 35-bit trial subtract on the
// partial remainder; an item takes one load and 32 iterations. The root is
// captured on the last iteration, as the block returns to idle and can accept
// the next item. Results sit in an output register; the next item is
// accepted while a result waits, and the last iteration holds only if the
// previous result is still untaken. The block handles one item at a time.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module integer_square_root_64
    import isqrt_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    isqrt_in_if.sink      in,
    isqrt_out_if.source   out
);

    isqrt_cmd_t    cmd;
    isqrt_status_t status;

    isqrt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in.valid),
        .in_ready  (in.ready),
        .out_valid (out.valid),
        .out_ready (out.ready),
        .status    (status),
        .cmd       (cmd)
    );

    isqrt_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .radicand (in.radicand),
        .cmd      (cmd),
        .status   (status),
        .root     (out.root)
    );

    `ASSERT_PROP(a_busy_after_accept, in.valid && in.ready |=> !in.ready, "accepted item did not start")
    `ASSERT_PROP(a_capture_sets_valid, cmd.capture |=> out.valid, "captured root not presented")
    `ASSERT_NEVER(a_load_and_step, cmd.load && cmd.step, "load and iterate in one cycle")

endmodule
